// ===== design/flrp_pkg.sv =====
`timescale 1ns / 1ps

package flrp_pkg;

  // frame type bytes
  localparam logic [7:0] TYPE_DATA = 8'h5a;
  localparam logic [7:0] TYPE_RESP = 8'haa;

  // header bytes before the payload of a data frame
  localparam logic [15:0] DATA_HEAD = 16'd7;

  // stream positions
  localparam logic [15:0] POS_START  = 16'd0;
  localparam logic [15:0] POS_SEEN   = 16'd2;
  localparam logic [15:0] POS_COUNT  = 16'd3;
  localparam logic [15:0] POS_FORMAT = 16'd4;
  localparam logic [15:0] POS_LEN_HI = 16'd5;
  localparam logic [15:0] POS_LEN_LO = 16'd6;

  // result event codes
  localparam logic [2:0] EV_PAYLOAD   = 3'd0;
  localparam logic [2:0] EV_DATA_OK   = 3'd1;
  localparam logic [2:0] EV_DATA_BAD  = 3'd2;
  localparam logic [2:0] EV_RESP_OK   = 3'd3;
  localparam logic [2:0] EV_RESP_BAD  = 3'd4;
  localparam logic [2:0] EV_TIMEOUT   = 3'd5;
  localparam logic [2:0] EV_TOO_LONG  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [1:0] CFG_START_SECOND = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [7:0]  start_first;
    logic [7:0]  start_second;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  rolling_count;
    logic [7:0]  encrypt_format;
    logic [15:0] payload_length;
    logic        last_flag;
  } res_t;

endpackage

// ===== design/framed_link_receive_parser.sv =====
`timescale 1ns / 1ps

// Receive-side deframer for a byte link. Each input item is one received byte
// (mode 0) or one timer tick (mode 1). Items are taken at one per clock while
// no result is stalled. When an item causes a result, out_valid rises once
// the item has passed the input register and its result has entered the
// result register, which then holds the result until it is taken. The parse
// state (phase, position, running XOR, idle tick count) is updated by a
// single compare-and-XOR step per item, which is what holds the rate at one
// item per cycle while no result is stalled. A stalled result holds the
// parse stage; the input register still takes one further item meanwhile.
// Configuration writes are accepted every cycle (cfg_ready is always high)
// and must only be made while the block is idle. Frames declaring more than
// MAX_PAYLOAD payload bytes are dropped with a too-long verdict.
module framed_link_receive_parser #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_rolling_count,
  output logic [7:0]  out_encrypt_format,
  output logic [15:0] out_payload_length,
  output logic        out_last_flag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import flrp_pkg::*;

  cfg_t        cfg;
  res_t        res;
  res_t        res_q;
  logic        res_valid;
  logic        out_full;
  logic        in_v_r;
  logic        in_mode_r;
  logic [7:0]  in_byte_r;
  logic        advance;
  logic        in_take;

  assign cfg_ready = 1'b1;

  flrp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // parse stage moves only when the result register can take its output
  assign advance  = in_v_r && !(out_full && out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r <= in_mode;
      in_byte_r <= in_data_byte;
    end
  end

  flrp_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .mode      (in_mode_r),
    .data_byte (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  flrp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .stall     (out_stall),
    .full      (out_full),
    .res_out   (res_q)
  );

  assign out_valid          = out_full;
  assign out_event_res      = res_q.event_res;
  assign out_payload_byte   = res_q.payload_byte;
  assign out_rolling_count  = res_q.rolling_count;
  assign out_encrypt_format = res_q.encrypt_format;
  assign out_payload_length = res_q.payload_length;
  assign out_last_flag      = res_q.last_flag;

  // input side only holds off while a result is waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_last_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_flag == (out_event_res != EV_PAYLOAD)))
    else $error("last flag disagrees with event");

  a_resp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == EV_RESP_OK || out_event_res == EV_RESP_BAD))
      |-> (out_encrypt_format == 8'd0 && out_payload_length == 16'd0))
    else $error("response verdict carries data frame fields");

  a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_PAYLOAD) |-> (out_payload_byte == 8'd0))
    else $error("payload byte set on a verdict");

endmodule

// ===== design/flrp_cfg.sv =====
`timescale 1ns / 1ps

module flrp_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data,
  output flrp_pkg::cfg_t     cfg
);
  import flrp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_first   <= 8'd0;
      cfg_r.start_second  <= 8'd0;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_START_FIRST:  cfg_r.start_first   <= wr_data[7:0];
        CFG_START_SECOND: cfg_r.start_second  <= wr_data[7:0];
        CFG_TIMEOUT:      cfg_r.timeout_ticks <= wr_data;
        default: ;        // no register there
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/flrp_core.sv =====
`timescale 1ns / 1ps

module flrp_core #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               mode,
  input  logic [7:0]         data_byte,
  input  flrp_pkg::cfg_t     cfg,
  output logic               res_valid,
  output flrp_pkg::res_t     res
);
  import flrp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HUNT = 4'b0010,
    PH_DATA = 4'b0100,
    PH_RESP = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [7:0]  fcnt_r, fcnt_nxt;
  logic [7:0]  fmt_r, fmt_nxt;
  logic [15:0] len_r, len_nxt;

  logic [15:0] tick_inc;
  logic [16:0] limit;
  logic [2:0]  ev;
  logic        emit;
  logic        is_data;

  assign tick_inc = (idle_r == 16'hffff) ? idle_r : idle_r + 16'd1;
  assign limit    = {1'b0, len_r} + {1'b0, DATA_HEAD};

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    idle_nxt  = idle_r;
    fcnt_nxt  = fcnt_r;
    fmt_nxt   = fmt_r;
    len_nxt   = len_r;
    emit      = 1'b0;
    ev        = EV_PAYLOAD;

    if (mode) begin
      if (phase_r != PH_IDLE) begin
        idle_nxt = tick_inc;
        if (tick_inc > cfg.timeout_ticks) begin
          // silent in the hunt, a verdict inside a frame
          emit      = (phase_r == PH_DATA) || (phase_r == PH_RESP);
          ev        = EV_TIMEOUT;
          phase_nxt = PH_IDLE;
          pos_nxt   = POS_START;
          idle_nxt  = 16'd0;
        end
      end
    end else begin
      idle_nxt = 16'd0;
      unique case (phase_r)
        PH_IDLE: begin
          prev_nxt  = data_byte;
          pos_nxt   = POS_START;
          phase_nxt = PH_HUNT;
        end
        PH_HUNT: begin
          if (pos_r != POS_SEEN) begin
            if (prev_r == cfg.start_first && data_byte == cfg.start_second) begin
              pos_nxt = POS_SEEN;
            end
            prev_nxt = data_byte;
          end else if (data_byte == TYPE_DATA || data_byte == TYPE_RESP) begin
            phase_nxt = (data_byte == TYPE_DATA) ? PH_DATA : PH_RESP;
            pos_nxt   = POS_COUNT;
            xor_nxt   = data_byte;
            fcnt_nxt  = 8'd0;
            fmt_nxt   = 8'd0;
            len_nxt   = 16'd0;
          end else begin
            // unknown type: it may itself open the next start pattern
            pos_nxt  = POS_START;
            prev_nxt = data_byte;
          end
        end
        PH_DATA: begin
          pos_nxt = pos_r + 16'd1;
          priority if (pos_r == POS_COUNT) begin
            fcnt_nxt = data_byte;
            xor_nxt  = xor_r ^ data_byte;
          end else if (pos_r == POS_FORMAT) begin
            fmt_nxt = data_byte;
            xor_nxt = xor_r ^ data_byte;
          end else if (pos_r == POS_LEN_HI) begin
            len_nxt = {data_byte, 8'd0};
            xor_nxt = xor_r ^ data_byte;
          end else if (pos_r == POS_LEN_LO) begin
            len_nxt = {len_r[15:8], data_byte};
            xor_nxt = xor_r ^ data_byte;
            if ({len_r[15:8], data_byte} > 16'(MAX_PAYLOAD)) begin
              emit      = 1'b1;
              ev        = EV_TOO_LONG;
              phase_nxt = PH_IDLE;
              pos_nxt   = POS_START;
            end
          end else if ({1'b0, pos_r} < limit) begin
            xor_nxt = xor_r ^ data_byte;
            emit    = 1'b1;
            ev      = EV_PAYLOAD;
          end else begin
            emit      = 1'b1;
            ev        = (xor_r == data_byte) ? EV_DATA_OK : EV_DATA_BAD;
            phase_nxt = PH_IDLE;
            pos_nxt   = POS_START;
          end
        end
        PH_RESP: begin
          if (pos_r == POS_COUNT) begin
            fcnt_nxt = data_byte;
            xor_nxt  = xor_r ^ data_byte;
            pos_nxt  = POS_FORMAT;
          end else begin
            emit      = 1'b1;
            ev        = (xor_r == data_byte) ? EV_RESP_OK : EV_RESP_BAD;
            phase_nxt = PH_IDLE;
            pos_nxt   = POS_START;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // header fields as they stand once this item is taken in
  assign is_data            = (phase_r == PH_DATA);
  assign res_valid          = step && emit;
  assign res.event_res      = ev;
  assign res.payload_byte   = (ev == EV_PAYLOAD) ? data_byte : 8'd0;
  assign res.rolling_count  = fcnt_nxt;
  assign res.encrypt_format = is_data ? fmt_nxt : 8'd0;
  assign res.payload_length = is_data ? len_nxt : 16'd0;
  assign res.last_flag      = (ev != EV_PAYLOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prev_r  <= 8'd0;
      pos_r   <= POS_START;
      xor_r   <= 8'd0;
      idle_r  <= 16'd0;
      fcnt_r  <= 8'd0;
      fmt_r   <= 8'd0;
      len_r   <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
      idle_r  <= idle_nxt;
      fcnt_r  <= fcnt_nxt;
      fmt_r   <= fmt_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== design/flrp_out_stage.sv =====
`timescale 1ns / 1ps

module flrp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  flrp_pkg::res_t     res,
  input  logic               stall,
  output logic               full,
  output flrp_pkg::res_t     res_out
);
  import flrp_pkg::*;

  logic full_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (!full_r || !stall) begin
      full_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!full_r || !stall) begin
      res_r <= res;
    end
  end

  assign full    = full_r;
  assign res_out = res_r;

endmodule
